// ===== rtl/tsga_pkg.sv =====
// Package for the two-sided cell grid allocator.
// Holds cell codes, action and register codes, the state type and shared structs.
// No dependencies.
package tsga_pkg;

    localparam int ROW_W  = 4;
    localparam int COL_W  = 4;
    localparam int SIZE_W = 5;
    localparam int IDX_W  = 2;

    localparam logic [1:0] CELL_FREE     = 2'd0;
    localparam logic [1:0] CELL_RESERVED = 2'd1;
    localparam logic [1:0] CELL_OCCUPIED = 2'd2;

    localparam logic [IDX_W-1:0] CFG_ROWS    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DOUBLE  = 2'd2;

    typedef enum logic [1:0] {
        ACT_RESERVE = 2'd0,
        ACT_CANCEL  = 2'd1,
        ACT_OCCUPY  = 2'd2,
        ACT_REPLACE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CANCEL,
        ST_OCCUPY,
        ST_FULL_START,
        ST_FULL_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_all;
    } mem_ctl_t;

    typedef struct packed {
        logic             done_res;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_column;
        logic             side_full;
        logic             side_now;
    } result_t;

endpackage

// ===== rtl/tsga_ifs.sv =====
// Channel interfaces of the two-sided cell grid allocator: request, response, configuration.
// Depends on tsga_pkg for the field widths.
interface tsga_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [tsga_pkg::ROW_W-1:0] row;
    logic [tsga_pkg::COL_W-1:0] column;

    modport source (output valid, output action, output row, output column, input ready);
    modport sink (input valid, input action, input row, input column, output ready);
endinterface

interface tsga_out_if;
    logic                      valid;
    logic                      ready;
    logic                      done_res;
    logic [tsga_pkg::ROW_W-1:0] cell_row;
    logic [tsga_pkg::COL_W-1:0] cell_column;
    logic                      side_full;
    logic                      side_now;

    modport source (output valid, output done_res, output cell_row, output cell_column,
                    output side_full, output side_now, input ready);
    modport sink (input valid, input done_res, input cell_row, input cell_column,
                  input side_full, input side_now, output ready);
endinterface

interface tsga_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [tsga_pkg::IDX_W-1:0]  idx;
    logic [tsga_pkg::SIZE_W-1:0] wdata;

    modport source (output valid, output idx, output wdata, input ready);
    modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ===== rtl/tsga_row_mem.sv =====
// Row memory of the allocator: one word of cell codes per side and row, with a registered read.
// Per-row valid bits make unwritten or cleared rows read as all free. Depends on tsga_pkg.
module tsga_row_mem #(
    parameter int ROW_AW = 5,
    parameter int WORD_W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsga_pkg::mem_ctl_t    ctl,
    input  logic [ROW_AW-1:0]     rd_addr,
    input  logic [ROW_AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0]     wr_data,
    output logic [WORD_W-1:0]     rd_word
);
    import tsga_pkg::*;

    localparam int DEPTH = 2 ** ROW_AW;

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/tsga_ctrl.sv =====
// Sequencer of the allocator: decodes each request, scans rows of the memory one per cycle,
// modifies and writes back row words and forms the result. Depends on tsga_pkg.
module tsga_ctrl #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 16,
    parameter int ROW_AW      = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    action,
    input  logic [tsga_pkg::ROW_W-1:0]    row,
    input  logic [tsga_pkg::COL_W-1:0]    column,
    input  logic [tsga_pkg::SIZE_W-1:0]   rows_eff,
    input  logic [tsga_pkg::SIZE_W-1:0]   cols_eff,
    input  logic                          double_sided,
    input  logic                          result_take,
    input  logic [2*MAX_COLUMNS-1:0]      rd_word,
    output logic                          idle,
    output tsga_pkg::mem_ctl_t            mem_ctl,
    output logic [ROW_AW-1:0]             rd_addr,
    output logic [ROW_AW-1:0]             wr_addr,
    output logic [2*MAX_COLUMNS-1:0]      wr_data,
    output logic                          result_valid,
    output tsga_pkg::result_t             result
);
    import tsga_pkg::*;

    localparam int RW = ROW_AW - 1;
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    state_t             state_reg, state_next;
    logic               side_reg, side_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      scan_row_reg, scan_row_next;
    result_t            res_reg, res_next;

    logic [MAX_COLUMNS-1:0] free_hit;
    logic [MAX_COLUMNS-1:0] occ_ok;
    logic                   found;
    logic [CW-1:0]          first_col;
    logic                   row_full;
    logic                   last_row;
    logic                   in_range;

    always_comb
    begin
        found     = 1'b0;
        first_col = '0;
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            free_hit[c] = (c < int'(cols_eff)) && (rd_word[2*c +: 2] == CELL_FREE);
            occ_ok[c]   = (c >= int'(cols_eff)) || (rd_word[2*c +: 2] == CELL_OCCUPIED);
        end
        for (int c = MAX_COLUMNS - 1; c >= 0; c--)
        begin
            if (free_hit[c])
            begin
                found     = 1'b1;
                first_col = CW'(c);
            end
        end
    end

    assign row_full = &occ_ok;
    assign last_row = (7'(scan_row_reg) + 7'd1) >= 7'(rows_eff);
    assign in_range = ({1'b0, row} < rows_eff) && ({1'b0, column} < cols_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        scan_row_reg <= scan_row_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        side_next     = side_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        scan_row_next = scan_row_reg;
        res_next      = res_reg;
        mem_ctl       = '0;
        rd_addr       = {side_reg, scan_row_reg + RW'(1)};
        wr_addr       = {side_reg, row_reg};
        wr_data       = rd_word;
        idle          = 1'b0;
        result_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    row_next          = RW'(row);
                    col_next          = CW'(column);
                    res_next          = '0;
                    res_next.side_now = side_reg;
                    state_next        = ST_EMIT;
                    unique case (action_t'(action))
                        ACT_RESERVE:
                        begin
                            if ((rows_eff != '0) && (cols_eff != '0))
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = {side_reg, RW'(0)};
                                scan_row_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            if (in_range)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = {side_reg, RW'(row)};
                                state_next    = ST_CANCEL;
                            end
                        end
                        ACT_OCCUPY:
                        begin
                            if (in_range)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = {side_reg, RW'(row)};
                                state_next    = ST_OCCUPY;
                            end
                        end
                        ACT_REPLACE:
                        begin
                            if (double_sided && !side_reg)
                            begin
                                side_next = 1'b1;
                            end
                            else
                            begin
                                mem_ctl.clear_all = 1'b1;
                                side_next         = 1'b0;
                            end
                            res_next.done_res = 1'b1;
                            res_next.side_now = side_next;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (found)
                begin
                    mem_ctl.wr_en                 = 1'b1;
                    wr_addr                       = {side_reg, scan_row_reg};
                    wr_data[{first_col, 1'b0} +: 2] = CELL_RESERVED;
                    res_next.done_res             = 1'b1;
                    res_next.cell_row             = ROW_W'(scan_row_reg);
                    res_next.cell_column          = COL_W'(first_col);
                    state_next                    = ST_EMIT;
                end
                else if (last_row)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    scan_row_next = scan_row_reg + RW'(1);
                end
            end

            ST_CANCEL:
            begin
                if (rd_word[{col_reg, 1'b0} +: 2] == CELL_RESERVED)
                begin
                    mem_ctl.wr_en                  = 1'b1;
                    wr_data[{col_reg, 1'b0} +: 2]  = CELL_FREE;
                    res_next.done_res              = 1'b1;
                end
                state_next = ST_EMIT;
            end

            ST_OCCUPY:
            begin
                mem_ctl.wr_en                 = 1'b1;
                wr_data[{col_reg, 1'b0} +: 2] = CELL_OCCUPIED;
                res_next.done_res             = 1'b1;
                state_next                    = ST_FULL_START;
            end

            ST_FULL_START:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = {side_reg, RW'(0)};
                scan_row_next = '0;
                state_next    = ST_FULL_SCAN;
            end

            ST_FULL_SCAN:
            begin
                if (!row_full)
                begin
                    state_next = ST_EMIT;
                end
                else if (last_row)
                begin
                    res_next.side_full = 1'b1;
                    state_next         = ST_EMIT;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    scan_row_next = scan_row_reg + RW'(1);
                end
            end

            ST_EMIT:
            begin
                result_valid = 1'b1;
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result = res_reg;

endmodule

// ===== rtl/two_sided_cell_grid_allocator_top.sv =====
// Top level of the two-sided cell grid allocator.
// Instantiates tsga_ctrl and tsga_row_mem; uses tsga_pkg and the interfaces in tsga_ifs.sv.
//
// Usage: requests arrive on req (action, row, column), one result beat per request leaves
// on rsp, and register writes arrive on cfg, which is always ready. Registers must be
// written only while no request is outstanding; the block itself does not enforce this.
// The grid lives in a row memory, one word per side and row, read one row per cycle.
// Paths from an accepted request to its result beat on rsp:
//   replace and out-of-range cancel or occupy: straight to the result;
//   cancel: reads the addressed row and frees the cell if it was reserved;
//   reserve: scans the rows in use until a free cell is found or the rows run out;
//   occupy: writes the cell, then checks the rows in use for fullness until one is not full.
// A new request is taken once the previous result sits in the output register, so
// requests are handled one at a time and the sustained rate is set by the one-row-per-cycle
// scan of reserve and occupy.
// Reset empties the grid at once through per-row valid bits and selects side 0; there is
// no clearing pass. While rsp is stalled the result holds and at most one further request
// is processed up to its result, which then waits.
module two_sided_cell_grid_allocator_top #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLUMNS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tsga_in_if.sink    req,
    tsga_out_if.source rsp,
    tsga_cfg_if.sink   cfg
);
    import tsga_pkg::*;

    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW      = RW + 1;
    localparam int WW      = 2 * MAX_COLUMNS;
    localparam int ROW_CAP = (MAX_ROWS > 31) ? 31 : MAX_ROWS;
    localparam int COL_CAP = (MAX_COLUMNS > 31) ? 31 : MAX_COLUMNS;

    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    logic              double_reg;
    logic [SIZE_W-1:0] rows_eff;
    logic [SIZE_W-1:0] cols_eff;

    logic              out_valid_reg;
    result_t           out_reg;

    logic              idle;
    logic              result_valid;
    logic              result_take;
    result_t           result;
    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WW-1:0]     wr_data;
    logic [WW-1:0]     rd_word;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= SIZE_W'(16);
            cols_reg   <= SIZE_W'(16);
            double_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.idx)
                CFG_ROWS:    rows_reg   <= cfg.wdata;
                CFG_COLUMNS: cols_reg   <= cfg.wdata;
                CFG_DOUBLE:  double_reg <= cfg.wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    assign rows_eff = (rows_reg > SIZE_W'(ROW_CAP)) ? SIZE_W'(ROW_CAP) : rows_reg;
    assign cols_eff = (cols_reg > SIZE_W'(COL_CAP)) ? SIZE_W'(COL_CAP) : cols_reg;

    assign req.ready   = idle;
    assign result_take = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_take)
        begin
            out_valid_reg <= result_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_take && result_valid)
        begin
            out_reg <= result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.done_res    = out_reg.done_res;
    assign rsp.cell_row    = out_reg.cell_row;
    assign rsp.cell_column = out_reg.cell_column;
    assign rsp.side_full   = out_reg.side_full;
    assign rsp.side_now    = out_reg.side_now;

    tsga_ctrl #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROW_AW      (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (req.valid && idle),
        .action       (req.action),
        .row          (req.row),
        .column       (req.column),
        .rows_eff     (rows_eff),
        .cols_eff     (cols_eff),
        .double_sided (double_reg),
        .result_take  (result_take),
        .rd_word      (rd_word),
        .idle         (idle),
        .mem_ctl      (mem_ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .result_valid (result_valid),
        .result       (result)
    );

    tsga_row_mem #(
        .ROW_AW (AW),
        .WORD_W (WW)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_word (rd_word)
    );

endmodule

// ===== rtl/tsga_checker.sv =====
// Port-level checks for the two-sided cell grid allocator, bound to its top level.
// Depends on the top level's interface ports only.
module tsga_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       done_res,
    input logic [3:0] cell_row,
    input logic [3:0] cell_column,
    input logic       side_full
);

    // A result beat that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    // A failed action reports no position and no full side.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !done_res |-> cell_row == 4'd0 && cell_column == 4'd0 && !side_full)
        else $error("failed action carries a position or full flag");

    // A full side is only reported by an action that took effect.
    a_full_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && side_full |-> done_res)
        else $error("side_full without done_res");

    // The block works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

endmodule

bind two_sided_cell_grid_allocator_top tsga_checker u_tsga_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .done_res    (rsp.done_res),
    .cell_row    (rsp.cell_row),
    .cell_column (rsp.cell_column),
    .side_full   (rsp.side_full)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the two-sided cell grid allocator.
// Drives requests and register writes, predicts every result beat and checks it.
// Depends on tsga_pkg, the channel interfaces and the top level of the block.
`timescale 1ns / 1ps

module tb_top;
    import tsga_pkg::*;

    localparam int GRID_ROWS      = 16;
    localparam int GRID_COLUMNS   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        action_t          act;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } grid_req_t;

    logic clk = 1'b0;
    logic rst_n;

    tsga_in_if  req_if ();
    tsga_out_if rsp_if ();
    tsga_cfg_if cfg_if ();

    two_sided_cell_grid_allocator_top #(
        .MAX_ROWS    (GRID_ROWS),
        .MAX_COLUMNS (GRID_COLUMNS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    logic [1:0]        grid_cells [2][GRID_ROWS][GRID_COLUMNS];
    logic              grid_side;
    logic [SIZE_W-1:0] cfg_rows;
    logic [SIZE_W-1:0] cfg_cols;
    logic              cfg_double;

    grid_req_t   req_pending [$];
    result_t     predicted_rsp [$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int          grid_errors;

    always #5 clk = ~clk;

    function automatic int rows_live();
        return (cfg_rows > GRID_ROWS) ? GRID_ROWS : int'(cfg_rows);
    endfunction

    function automatic int cols_live();
        return (cfg_cols > GRID_COLUMNS) ? GRID_COLUMNS : int'(cfg_cols);
    endfunction

    function automatic result_t predict_grid_action(input grid_req_t q);
        result_t res;
        int      nr;
        int      nc;
        logic    hit;
        logic    all_occupied;
        logic    in_area;
        res = '0;
        nr = rows_live();
        nc = cols_live();
        hit = 1'b0;
        in_area = (int'(q.row) < nr) && (int'(q.col) < nc);
        case (q.act)
            ACT_RESERVE:
            begin
                for (int r = 0; r < nr; r++)
                begin
                    for (int c = 0; c < nc; c++)
                    begin
                        if (!hit && grid_cells[grid_side][r][c] == CELL_FREE)
                        begin
                            grid_cells[grid_side][r][c] = CELL_RESERVED;
                            hit = 1'b1;
                            res.done_res = 1'b1;
                            res.cell_row = 4'(r);
                            res.cell_column = 4'(c);
                        end
                    end
                end
            end
            ACT_CANCEL:
            begin
                if (in_area && grid_cells[grid_side][q.row][q.col] == CELL_RESERVED)
                begin
                    grid_cells[grid_side][q.row][q.col] = CELL_FREE;
                    res.done_res = 1'b1;
                end
            end
            ACT_OCCUPY:
            begin
                if (in_area)
                begin
                    grid_cells[grid_side][q.row][q.col] = CELL_OCCUPIED;
                    res.done_res = 1'b1;
                    all_occupied = 1'b1;
                    for (int r = 0; r < nr; r++)
                    begin
                        for (int c = 0; c < nc; c++)
                        begin
                            if (grid_cells[grid_side][r][c] != CELL_OCCUPIED)
                            begin
                                all_occupied = 1'b0;
                            end
                        end
                    end
                    res.side_full = all_occupied;
                end
            end
            default:
            begin
                if (cfg_double && grid_side == 1'b0)
                begin
                    grid_side = 1'b1;
                end
                else
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        for (int r = 0; r < GRID_ROWS; r++)
                        begin
                            for (int c = 0; c < GRID_COLUMNS; c++)
                            begin
                                grid_cells[s][r][c] = CELL_FREE;
                            end
                        end
                    end
                    grid_side = 1'b0;
                end
                res.done_res = 1'b1;
            end
        endcase
        res.side_now = grid_side;
        return res;
    endfunction

    task automatic log_error(input string msg);
        grid_errors++;
        if (grid_errors <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // Request driver: an offered beat is held until it is taken.
    always @(posedge clk)
    begin : driver
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                predicted_rsp.push_back(predict_grid_action(req_pending[0]));
                void'(req_pending.pop_front());
            end
            if (!(req_if.valid && !req_if.ready))
            begin
                if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_if.valid  <= 1'b1;
                    req_if.action <= req_pending[0].act;
                    req_if.row    <= req_pending[0].row;
                    req_if.column <= req_pending[0].col;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = '{done_res: rsp_if.done_res, cell_row: rsp_if.cell_row,
                        cell_column: rsp_if.cell_column, side_full: rsp_if.side_full,
                        side_now: rsp_if.side_now};
                if (predicted_rsp.size() == 0)
                begin
                    log_error($sformatf("tb_top: unexpected result beat %h", got));
                end
                else
                begin
                    want = predicted_rsp.pop_front();
                    if (got !== want)
                    begin
                        log_error($sformatf({"tb_top: mismatch at %0t: expected done %0d ",
                            "pos %0d,%0d full %0d side %0d, got done %0d pos %0d,%0d ",
                            "full %0d side %0d"}, $time,
                            want.done_res, want.cell_row, want.cell_column,
                            want.side_full, want.side_now,
                            got.done_res, got.cell_row, got.cell_column,
                            got.side_full, got.side_now));
                    end
                end
            end
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : hold_counter
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic push_req(input action_t act, input int row, input int col);
        req_pending.push_back('{act: act, row: 4'(row), col: 4'(col)});
    endtask

    task automatic drain(input int settle);
        while (req_pending.size() != 0 || predicted_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // All four indexes are written with valid held high throughout.
    task automatic write_regs(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                              input logic dbl);
        logic [IDX_W-1:0]  idx_seq [4];
        logic [SIZE_W-1:0] val_seq [4];
        idx_seq = '{CFG_ROWS, CFG_COLUMNS, CFG_SPARE, CFG_DOUBLE};
        val_seq = '{rows, cols, 5'($urandom), {4'($urandom), dbl}};
        for (int k = 0; k < 4; k++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.idx   <= idx_seq[k];
            cfg_if.wdata <= val_seq[k];
            @(posedge clk);
            while (!cfg_if.ready)
            begin
                @(posedge clk);
            end
            case (idx_seq[k])
                CFG_ROWS:    cfg_rows = val_seq[k];
                CFG_COLUMNS: cfg_cols = val_seq[k];
                CFG_DOUBLE:  cfg_double = val_seq[k][0];
                default:     ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int pick;
        pick = $urandom_range(9);
        if (pick <= 5)
        begin
            return 5'($urandom_range(4, 1));
        end
        else if (pick == 6)
        begin
            return 5'(GRID_ROWS);
        end
        else if (pick == 7)
        begin
            return 5'd0;
        end
        else if (pick == 8)
        begin
            return 5'($urandom_range(31, 17));
        end
        return 5'($urandom_range(15, 5));
    endfunction

    // Mostly in-area positions; small areas are sometimes filled completely.
    task automatic queue_random(input int n);
        int      made;
        int      nr;
        int      nc;
        int      pick;
        action_t act;
        made = 0;
        nr = rows_live();
        nc = cols_live();
        while (made < n)
        begin
            if (nr * nc != 0 && nr * nc <= 16 && $urandom_range(3) == 0)
            begin
                for (int r = 0; r < nr; r++)
                begin
                    for (int c = 0; c < nc; c++)
                    begin
                        push_req(ACT_OCCUPY, r, c);
                    end
                end
                push_req(ACT_RESERVE, $urandom_range(15), $urandom_range(15));
                push_req(ACT_REPLACE, $urandom_range(15), $urandom_range(15));
                made += nr * nc + 2;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 38)
                begin
                    act = ACT_RESERVE;
                end
                else if (pick < 60)
                begin
                    act = ACT_CANCEL;
                end
                else if (pick < 92)
                begin
                    act = ACT_OCCUPY;
                end
                else
                begin
                    act = ACT_REPLACE;
                end
                if (nr * nc != 0 && $urandom_range(4) != 0)
                begin
                    push_req(act, $urandom_range(nr - 1), $urandom_range(nc - 1));
                end
                else
                begin
                    push_req(act, $urandom_range(15), $urandom_range(15));
                end
                made++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
        req_if.valid  = 1'b0;
        req_if.action = ACT_RESERVE;
        req_if.row    = '0;
        req_if.column = '0;
        rsp_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.idx    = CFG_ROWS;
        cfg_if.wdata  = '0;
        rst_n = 1'b0;
        grid_errors = 0;
        quiet_cycles = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int s = 0; s < 2; s++)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
            begin
                for (int c = 0; c < GRID_COLUMNS; c++)
                begin
                    grid_cells[s][r][c] = CELL_FREE;
                end
            end
        end
        grid_side = 1'b0;
        cfg_rows = 5'd16;
        cfg_cols = 5'd16;
        cfg_double = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-size single-sided grid as left by reset.
        push_req(ACT_RESERVE, 0, 0);
        push_req(ACT_RESERVE, 15, 15);
        push_req(ACT_CANCEL, 0, 1);
        push_req(ACT_CANCEL, 0, 1);
        push_req(ACT_CANCEL, 15, 15);
        push_req(ACT_OCCUPY, 15, 15);
        push_req(ACT_CANCEL, 15, 15);
        push_req(ACT_OCCUPY, 0, 0);
        push_req(ACT_RESERVE, 0, 0);
        push_req(ACT_REPLACE, 0, 0);
        drain(4);

        // One cell, double sided: no free cell, full side, both replace paths.
        write_regs(5'd1, 5'd1, 1'b1);
        push_req(ACT_RESERVE, 0, 0);
        push_req(ACT_RESERVE, 0, 0);
        push_req(ACT_CANCEL, 0, 0);
        push_req(ACT_OCCUPY, 0, 0);
        push_req(ACT_OCCUPY, 0, 15);
        push_req(ACT_CANCEL, 15, 0);
        push_req(ACT_REPLACE, 0, 0);
        push_req(ACT_OCCUPY, 0, 0);
        push_req(ACT_REPLACE, 0, 0);
        drain(4);

        // No rows in use and columns saturated.
        write_regs(5'd0, 5'd31, 1'b0);
        push_req(ACT_RESERVE, 0, 0);
        push_req(ACT_CANCEL, 0, 0);
        push_req(ACT_OCCUPY, 0, 0);
        push_req(ACT_REPLACE, 0, 0);
        drain(4);

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct = 29;
                    recv_stall_pct = 29;
                end
            endcase
            rows = pick_size();
            cols = pick_size();
            if (ph == 0)
            begin
                rows = 5'd16;
                cols = 5'd16;
            end
            else if (ph == 1)
            begin
                rows = 5'd1;
                cols = 5'd1;
            end
            else if (ph == 2)
            begin
                rows = 5'd31;
                cols = 5'd0;
            end
            write_regs(rows, cols, 1'($urandom_range(1)));
            if (ph == 4)
            begin
                hold_left <= HOLD_CYCLES;
            end
            queue_random(52);
            drain(4);
        end

        drain(20);
        while (predicted_rsp.size() != 0)
        begin
            void'(predicted_rsp.pop_front());
            log_error("tb_top: result beat never arrived");
        end
        if (grid_errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
